// ----- rtl/rna_pkg.sv -----
// shared types and constants for the rational number alu
`default_nettype none
package rna_pkg;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_NEG    = 4'd4,
      OP_INC    = 4'd5,
      OP_DEC    = 4'd6,
      OP_EQ     = 4'd7,
      OP_GT     = 4'd8,
      OP_GE     = 4'd9,
      OP_LT     = 4'd10,
      OP_LE     = 4'd11,
      OP_TOINT  = 4'd12,
      OP_REDUCE = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DIVZERO = 2'd1,
      ST_OVF     = 2'd2,
      ST_ZERODEN = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_GCD,      // repeated remainder on magnitudes
      S_GCD_DIV,  // divide denominators (add/sub) or a_num/a_den (reduce) by gcd
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_DIVOP,    // toint quotient
      S_FINISH,
      S_OUT
   } state_type;

   localparam int unsigned OP_BITS     = 4;
   localparam int unsigned STATUS_BITS = 2;

endpackage
`default_nettype wire

// ----- rtl/rna_if.sv -----
// valid/ready channel interfaces for the rational number alu
`default_nettype none
interface rna_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic [rna_pkg::OP_BITS-1:0] operation;
   logic signed [WORD_BITS-1:0] a_num;
   logic signed [WORD_BITS-1:0] a_den;
   logic signed [WORD_BITS-1:0] b_num;
   logic signed [WORD_BITS-1:0] b_den;
   modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_rsp_if #(parameter int WORD_BITS = 32);
   logic                            valid;
   logic                            ready;
   logic signed [WORD_BITS-1:0]     res_num;
   logic signed [WORD_BITS-1:0]     res_den;
   logic                            compare_true;
   logic [rna_pkg::STATUS_BITS-1:0] status;
   modport source (output valid, res_num, res_den, compare_true, status, input ready);
   modport sink   (input valid, res_num, res_den, compare_true, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/rna_divider.sv -----
// iterative unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module rna_divider #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ----- rtl/rational_number_alu.sv -----
// top level of the rational number alu: sequencer around shared divider and multiplier
//
//  channel | direction | payload
//  req     | in        | operation, a_num, a_den, b_num, b_den
//  rsp     | out       | res_num, res_den, compare_true, status
//
// one item at a time; req_ready only in idle
// every divider run holds its state from start through the quotient bits to done
// neg, inc and dec go from the check straight to finish; mul, div and the comparisons
// pass through mul1, mul2 and mul3; toint takes one divider run; add, sub and reduce take
// one run per gcd remainder (the euclid chain, up to about 1.44*W for full-width operands)
// plus two runs for the exact divisions by the gcd, then mul1 to mul3 for add and sub
// reset (synchronous, active high) returns the sequencer to idle with no result pending
// a stalled result holds in the output register until rsp_ready
`default_nettype none
module rational_number_alu #(
   parameter int WORD_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   rna_req_if.sink    req,
   rna_rsp_if.source  rsp
);
   localparam int W  = WORD_BITS;
   localparam int W2 = 2 * WORD_BITS;

   typedef logic signed [W-1:0]  word_type;
   typedef logic signed [W2-1:0] dword_type;

   rna_pkg::state_type state_ff, state_in;

   // captured operands
   rna_pkg::op_type op_ff;
   word_type an_ff, ad_ff, bn_ff, bd_ff;
   // gcd magnitudes
   logic [W-1:0] p_ff, p_in, q_ff, q_in;
   // scaled denominators / working values
   word_type ga_ff, ga_in, gb_ff, gb_in;
   logic     gstep_ff, gstep_in;   // which gcd quotient is pending
   // products
   dword_type t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   // result
   word_type rn_ff, rn_in, rd_ff, rd_in;
   logic     cmp_ff, cmp_in;
   rna_pkg::status_type st_ff, st_in;
   logic     ovf_ff, ovf_in;

   // shared divider
   logic         div_start;
   logic [W-1:0] div_a, div_b;
   logic         div_done;
   logic [W-1:0] div_q, div_r;
   logic         div_wait_ff, div_wait_in;

   // shared multiplier
   word_type  mul_a, mul_b;
   dword_type mul_p;

   rna_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign mul_p = dword_type'(mul_a) * dword_type'(mul_b);

   function automatic logic [W-1:0] mag(input word_type x);
      mag = x[W-1] ? W'(-x) : W'(x);
   endfunction

   function automatic logic fits(input dword_type v);
      fits = (v >= -(dword_type'(1) <<< (W - 1))) && (v < (dword_type'(1) <<< (W - 1)));
   endfunction

   logic unary;
   assign unary = (op_ff == rna_pkg::OP_NEG) || (op_ff == rna_pkg::OP_INC) ||
                  (op_ff == rna_pkg::OP_DEC) || (op_ff == rna_pkg::OP_TOINT) ||
                  (op_ff == rna_pkg::OP_REDUCE);

   logic gcd_src_red;
   assign gcd_src_red = (op_ff == rna_pkg::OP_REDUCE);

   logic [W-1:0] g_val;
   assign g_val = (p_ff > q_ff) ? p_ff : q_ff;

   // signed quotient: the sign of x applied to the exact unsigned quotient uq of |x| by g
   function automatic word_type sdiv_fix(input word_type x, input logic [W-1:0] uq);
      sdiv_fix = x[W-1] ? word_type'(-uq) : word_type'(uq);
   endfunction

   dword_type sum_d;
   logic      cmp_c_gt, cmp_c_lt, sign_flip, c_pos, c_neg;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rna_pkg::S_IDLE:    if (req.valid) state_in = rna_pkg::S_CHECK;
         rna_pkg::S_CHECK: begin
            if (ad_ff == '0 || (!unary && bd_ff == '0) ||
                (op_ff == rna_pkg::OP_DIV && bn_ff == '0) || op_ff > rna_pkg::OP_REDUCE)
               state_in = rna_pkg::S_OUT;
            else case (op_ff)
               rna_pkg::OP_ADD, rna_pkg::OP_SUB, rna_pkg::OP_REDUCE:
                  state_in = rna_pkg::S_GCD;
               rna_pkg::OP_TOINT: state_in = rna_pkg::S_DIVOP;
               rna_pkg::OP_NEG, rna_pkg::OP_INC, rna_pkg::OP_DEC:
                  state_in = rna_pkg::S_FINISH;
               default: state_in = rna_pkg::S_MUL1;
            endcase
         end
         rna_pkg::S_GCD:
            if (div_wait_ff ? div_done && (div_r == '0 || (gstep_ff ? p_ff : q_ff) == '0) : 1'b0)
               state_in = rna_pkg::S_GCD_DIV;
            else if (!div_wait_ff && (p_ff == '0 || q_ff == '0))
               state_in = rna_pkg::S_GCD_DIV;
         rna_pkg::S_GCD_DIV:
            if (div_wait_ff && div_done && gstep_ff)
               state_in = gcd_src_red ? rna_pkg::S_FINISH : rna_pkg::S_MUL1;
         rna_pkg::S_MUL1: state_in = rna_pkg::S_MUL2;
         rna_pkg::S_MUL2: state_in = rna_pkg::S_MUL3;
         rna_pkg::S_MUL3: state_in = rna_pkg::S_FINISH;
         rna_pkg::S_DIVOP:
            if (div_wait_ff && div_done) state_in = rna_pkg::S_FINISH;
         rna_pkg::S_FINISH: state_in = rna_pkg::S_OUT;
         rna_pkg::S_OUT:    if (rsp.ready) state_in = rna_pkg::S_IDLE;
         default:           state_in = rna_pkg::S_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      p_in = p_ff; q_in = q_ff; ga_in = ga_ff; gb_in = gb_ff; gstep_in = gstep_ff;
      t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff;
      rn_in = rn_ff; rd_in = rd_ff; cmp_in = cmp_ff; st_in = st_ff; ovf_in = ovf_ff;
      div_wait_in = div_wait_ff;
      div_start = 1'b0; div_a = p_ff; div_b = q_ff;
      mul_a = an_ff; mul_b = bn_ff;
      sum_d = '0;
      sign_flip = ad_ff[W-1] ^ bd_ff[W-1];
      cmp_c_gt = t1_ff > t2_ff;
      cmp_c_lt = t1_ff < t2_ff;
      c_pos = sign_flip ? cmp_c_lt : cmp_c_gt;
      c_neg = sign_flip ? cmp_c_gt : cmp_c_lt;
      case (state_ff)
         rna_pkg::S_CHECK: begin
            rn_in = '0; rd_in = word_type'(1); cmp_in = 1'b0; ovf_in = 1'b0;
            st_in = rna_pkg::ST_OK; div_wait_in = 1'b0; gstep_in = 1'b0;
            // undefined codes never flag a zero denominator
            if (op_ff <= rna_pkg::OP_REDUCE && (ad_ff == '0 || (!unary && bd_ff == '0)))
               st_in = rna_pkg::ST_ZERODEN;
            else if (op_ff == rna_pkg::OP_DIV && bn_ff == '0)
               st_in = rna_pkg::ST_DIVZERO;
            p_in = gcd_src_red ? mag(an_ff) : mag(ad_ff);
            q_in = gcd_src_red ? mag(ad_ff) : mag(bd_ff);
         end
         rna_pkg::S_GCD: begin
            // larger %= smaller, one remainder per divider run
            if (!div_wait_ff) begin
               if (p_ff != '0 && q_ff != '0) begin
                  gstep_in    = (p_ff >= q_ff);
                  div_a       = (p_ff >= q_ff) ? p_ff : q_ff;
                  div_b       = (p_ff >= q_ff) ? q_ff : p_ff;
                  div_start   = 1'b1;
                  div_wait_in = 1'b1;
               end else begin
                  gstep_in = 1'b0;
               end
            end else if (div_done) begin
               div_wait_in = 1'b0;
               if (gstep_ff) p_in = div_r; else q_in = div_r;
               gstep_in = 1'b0;
            end
         end
         rna_pkg::S_GCD_DIV: begin
            // two exact divisions by g: first value then second
            if (!div_wait_ff) begin
               div_a = gstep_ff ? (gcd_src_red ? mag(ad_ff) : mag(bd_ff))
                                : (gcd_src_red ? mag(an_ff) : mag(ad_ff));
               div_b = g_val;
               div_start = 1'b1;
               div_wait_in = 1'b1;
            end else if (div_done) begin
               div_wait_in = 1'b0;
               if (!gstep_ff) begin
                  ga_in = sdiv_fix(gcd_src_red ? an_ff : ad_ff, div_q);
                  gstep_in = 1'b1;
               end else begin
                  gb_in = sdiv_fix(gcd_src_red ? ad_ff : bd_ff, div_q);
               end
            end
         end
         rna_pkg::S_MUL1: begin
            case (op_ff)
               rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin mul_a = an_ff; mul_b = gb_ff; end
               rna_pkg::OP_MUL: begin mul_a = an_ff; mul_b = bn_ff; end
               default:         begin mul_a = an_ff; mul_b = bd_ff; end
            endcase
            t1_in = mul_p;
         end
         rna_pkg::S_MUL2: begin
            case (op_ff)
               rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin mul_a = bn_ff; mul_b = ga_ff; end
               rna_pkg::OP_MUL: begin mul_a = ad_ff; mul_b = bd_ff; end
               rna_pkg::OP_DIV: begin mul_a = ad_ff; mul_b = bn_ff; end
               default:         begin mul_a = bn_ff; mul_b = ad_ff; end
            endcase
            t2_in = mul_p;
         end
         rna_pkg::S_MUL3: begin
            mul_a = ga_ff; mul_b = bd_ff;
            t3_in = mul_p;
         end
         rna_pkg::S_DIVOP: begin
            if (!div_wait_ff) begin
               div_a = mag(an_ff); div_b = mag(ad_ff);
               div_start = 1'b1; div_wait_in = 1'b1;
            end else if (div_done) begin
               div_wait_in = 1'b0;
               t1_in = (an_ff[W-1] ^ ad_ff[W-1]) ? -dword_type'({1'b0, div_q})
                                                 : dword_type'({1'b0, div_q});
            end
         end
         rna_pkg::S_FINISH: begin
            case (op_ff)
               rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin
                  sum_d = (op_ff == rna_pkg::OP_ADD) ? t1_ff + t2_ff : t1_ff - t2_ff;
                  if (!fits(t1_ff) || !fits(t2_ff) || !fits(t3_ff) || !fits(sum_d))
                     ovf_in = 1'b1;
                  rn_in = word_type'(sum_d); rd_in = word_type'(t3_ff);
               end
               rna_pkg::OP_MUL: begin
                  if (!fits(t1_ff) || !fits(t2_ff)) ovf_in = 1'b1;
                  rn_in = word_type'(t1_ff); rd_in = word_type'(t2_ff);
               end
               rna_pkg::OP_DIV: begin
                  sum_d = -t1_ff;
                  if (!fits(t1_ff) || !fits(t2_ff)) ovf_in = 1'b1;
                  else if (t2_ff[W2-1] && (!fits(sum_d) || !fits(-t2_ff))) ovf_in = 1'b1;
                  rn_in = t2_ff[W2-1] ? word_type'(sum_d) : word_type'(t1_ff);
                  rd_in = t2_ff[W2-1] ? word_type'(-t2_ff) : word_type'(t2_ff);
               end
               rna_pkg::OP_NEG: begin
                  sum_d = -dword_type'(an_ff);
                  ovf_in = !fits(sum_d);
                  rn_in = word_type'(sum_d); rd_in = ad_ff;
               end
               rna_pkg::OP_INC, rna_pkg::OP_DEC: begin
                  sum_d = (op_ff == rna_pkg::OP_INC) ? dword_type'(an_ff) + dword_type'(ad_ff)
                                                     : dword_type'(an_ff) - dword_type'(ad_ff);
                  ovf_in = !fits(sum_d);
                  rn_in = word_type'(sum_d); rd_in = ad_ff;
               end
               rna_pkg::OP_EQ, rna_pkg::OP_GT, rna_pkg::OP_GE, rna_pkg::OP_LT,
               rna_pkg::OP_LE: begin
                  case (op_ff)
                     rna_pkg::OP_EQ: cmp_in = !c_pos && !c_neg;
                     rna_pkg::OP_GT: cmp_in = c_pos;
                     rna_pkg::OP_GE: cmp_in = !c_neg;
                     rna_pkg::OP_LT: cmp_in = c_neg;
                     default:        cmp_in = !c_pos;
                  endcase
                  rn_in = cmp_in ? word_type'(1) : '0; rd_in = word_type'(1);
               end
               rna_pkg::OP_TOINT: begin
                  ovf_in = !fits(t1_ff);
                  rn_in = word_type'(t1_ff); rd_in = word_type'(1);
               end
               rna_pkg::OP_REDUCE: begin
                  rn_in = ga_ff; rd_in = gb_ff;
               end
               default: ;
            endcase
         end
         rna_pkg::S_OUT: begin
            if (ovf_ff && st_ff == rna_pkg::ST_OK) st_in = rna_pkg::ST_OVF;
         end
         default: ;
      endcase
   end

   // state and datapath registers; capture operands on an input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rna_pkg::S_IDLE;
         div_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         div_wait_ff <= div_wait_in;
      end
      if (state_ff == rna_pkg::S_IDLE && req.valid) begin
         op_ff <= rna_pkg::op_type'(req.operation);
         an_ff <= req.a_num; ad_ff <= req.a_den;
         bn_ff <= req.b_num; bd_ff <= req.b_den;
      end
      p_ff <= p_in; q_ff <= q_in; ga_ff <= ga_in; gb_ff <= gb_in; gstep_ff <= gstep_in;
      t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in;
      rn_ff <= rn_in; rd_ff <= rd_in; cmp_ff <= cmp_in; st_ff <= st_in; ovf_ff <= ovf_in;
   end

   // result register view: errors force 0/1
   logic err;
   assign err = (st_ff != rna_pkg::ST_OK) || ovf_ff;

   assign req.ready        = (state_ff == rna_pkg::S_IDLE);
   assign rsp.valid        = (state_ff == rna_pkg::S_OUT);
   assign rsp.res_num      = err ? '0 : rn_ff;
   assign rsp.res_den      = err ? word_type'(1) : rd_ff;
   assign rsp.compare_true = err ? 1'b0 : cmp_ff;
   assign rsp.status       = (st_ff != rna_pkg::ST_OK) ? st_ff
                             : (ovf_ff ? rna_pkg::ST_OVF : rna_pkg::ST_OK);

   // no input transfer while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("ready while result pending");
   // a result rises only out of the finish or the check state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff) == rna_pkg::S_FINISH ||
                           $past(state_ff) == rna_pkg::S_CHECK)
      else $error("result without sequence");
   // errors always read as zero over one; checked here on the numerator and compare_true
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != rna_pkg::ST_OK |-> rsp.res_num == '0 && !rsp.compare_true)
      else $error("error result not cleared");
endmodule
`default_nettype wire
